// ===== rtl/core/hsvrgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared constants and types for the HSV to ARGB conversion pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   localparam int HUE_W      = 16;
   localparam int DEG_FULL   = 360;
   localparam int DEG_SECTOR = 60;
   localparam int FRAC_ONE   = 255;
   localparam int DEN_QT     = FRAC_ONE * DEG_SECTOR;   // 15300

   // hue wrap: unsigned hue mod 360, plus fix-up for the 2^16 offset of negatives
   localparam int HUE_RECIP_SH = 22;
   localparam int HUE_RECIP    = ((1 << HUE_RECIP_SH) + DEG_FULL - 1) / DEG_FULL;
   localparam int HUE_NEG_ADJ  = DEG_FULL - ((1 << HUE_W) % DEG_FULL);

   // sector = hw / 60 for hw < 360
   localparam int SECT_RECIP_SH = 15;
   localparam int SECT_RECIP    = ((1 << SECT_RECIP_SH) + DEG_SECTOR - 1) / DEG_SECTOR;

   // floor reciprocals for the final divides; estimate is exact or one low
   localparam longint RECIP_255   = (64'd1 << 24) / FRAC_ONE;
   localparam longint RECIP_15300 = (64'd1 << 32) / DEN_QT;

   // sector codes
   localparam logic [2:0] SECT_RED_YEL   = 3'd0;
   localparam logic [2:0] SECT_YEL_GRN   = 3'd1;
   localparam logic [2:0] SECT_GRN_CYAN  = 3'd2;
   localparam logic [2:0] SECT_CYAN_BLUE = 3'd3;
   localparam logic [2:0] SECT_BLUE_MAG  = 3'd4;

   // fields that ride alongside the arithmetic
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] sat;
      logic [7:0] bri;
      logic [2:0] sector;
   } side_type;

endpackage

// ===== rtl/core/hsvrgb_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_scale
// Two-stage constant divider: p = xp/255, q = xq/15300, t = xt/15300,
// by reciprocal multiply followed by a single remainder correction.
// ----------------------------------------------------------------------------
module hsvrgb_scale import hsvrgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [15:0] xp,
   input  logic [21:0] xq,
   input  logic [21:0] xt,
   output logic        out_valid,
   output logic [7:0]  p,
   output logic [7:0]  q,
   output logic [7:0]  t
);

   logic [32:0] prod_p;
   logic [40:0] prod_q;
   logic [40:0] prod_t;

   logic        va_ff;
   logic [7:0]  ep_ff, eq_ff, et_ff;
   logic [15:0] xp_ff;
   logic [21:0] xq_ff, xt_ff;

   logic [15:0] rp;
   logic [21:0] rq, rt;
   logic [7:0]  p_in, q_in, t_in;

   logic        vb_ff;
   logic [7:0]  p_ff, q_ff, t_ff;

   // stage A: reciprocal estimates
   assign prod_p = 33'(xp) * 33'(RECIP_255);
   assign prod_q = 41'(xq) * 41'(RECIP_15300);
   assign prod_t = 41'(xt) * 41'(RECIP_15300);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ep_ff <= prod_p[31:24];
      eq_ff <= prod_q[39:32];
      et_ff <= prod_t[39:32];
      xp_ff <= xp;
      xq_ff <= xq;
      xt_ff <= xt;
   end

   // stage B: remainder check, bump the estimate if it came out one low
   always_comb begin
      rp = xp_ff - 16'(16'(ep_ff) * 16'(FRAC_ONE));
      rq = xq_ff - 22'(22'(eq_ff) * 22'(DEN_QT));
      rt = xt_ff - 22'(22'(et_ff) * 22'(DEN_QT));
      p_in = (rp >= 16'(FRAC_ONE)) ? ep_ff + 8'd1 : ep_ff;
      q_in = (rq >= 22'(DEN_QT))   ? eq_ff + 8'd1 : eq_ff;
      t_in = (rt >= 22'(DEN_QT))   ? et_ff + 8'd1 : et_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      q_ff <= q_in;
      t_ff <= t_in;
   end

   assign out_valid = vb_ff;
   assign p = p_ff;
   assign q = q_ff;
   assign t = t_ff;

endmodule

// ===== rtl/core/hsv_to_rgb_argb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_argb_core
// HSV plus alpha to ARGB byte conversion, fully pipelined.
// ----------------------------------------------------------------------------
// One item is taken per clock: busy is always low, so every cycle with start
// high is a transfer. Each result is shown for exactly one cycle with
// rsp_valid high, after the nine-stage arithmetic pipeline (hue wrap, sector
// split, numerators, products, reciprocal divide and correction, channel
// select). Results come out in order and are never held, so the receiver
// must take them as they come.
module hsv_to_rgb_argb_core import hsvrgb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_alpha_in,
   input  logic signed [15:0] req_hue,
   input  logic [7:0]         req_saturation,
   input  logic [7:0]         req_brightness,
   output logic               rsp_valid,
   output logic [7:0]         rsp_alpha_out,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue
);

   logic        accept;
   logic [15:0] hue_u;
   logic [29:0] hue_prod;

   // stage 1: hue quotient by 360
   logic        v1_ff;
   side_type    side1_ff, side1_in;
   logic [15:0] hu1_ff;
   logic        neg1_ff;
   logic [7:0]  hq1_ff;

   // stage 2: wrapped hue
   logic        v2_ff;
   side_type    side2_ff;
   logic [15:0] r2_full;
   logic [9:0]  r2_adj;
   logic [8:0]  hw2_in, hw2_ff;

   // stage 3: sector
   logic        v3_ff;
   side_type    side3_ff, side3_in;
   logic [18:0] sect_prod;
   logic [8:0]  hw3_ff;

   // stage 4: position within sector
   logic        v4_ff;
   side_type    side4_ff;
   logic [8:0]  sect60;
   logic [5:0]  fn4_in, fn4_ff;

   // stage 5: numerators
   logic        v5_ff;
   side_type    side5_ff;
   logic [13:0] sfn, sfn_c;
   logic [5:0]  fn_c;
   logic [7:0]  np5_ff;
   logic [13:0] nq5_ff, nt5_ff;

   // stage 6: products
   logic        v6_ff;
   side_type    side6_ff;
   logic [15:0] xp6_ff;
   logic [21:0] xq6_ff, xt6_ff;

   // stages 7-8: divider, side data delayed alongside
   side_type    side7_ff, side8_ff;
   logic        v8;
   logic [7:0]  p8, q8, t8;

   // stage 9: output
   logic        v9_ff;
   logic [7:0]  alpha9_ff, red9_ff, green9_ff, blue9_ff;
   logic [7:0]  red_in, green_in, blue_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ---- stage 1 ----
   assign hue_u    = $unsigned(req_hue);
   assign hue_prod = 30'(hue_u) * 30'(HUE_RECIP);

   always_comb begin
      side1_in        = '0;
      side1_in.alpha  = req_alpha_in;
      side1_in.sat    = req_saturation;
      side1_in.bri    = req_brightness;
   end

   always_ff @(posedge clock) begin
      side1_ff <= side1_in;
      hu1_ff   <= hue_u;
      neg1_ff  <= req_hue[15];
      hq1_ff   <= hue_prod[29:22];
   end

   // ---- stage 2 ----
   always_comb begin
      r2_full = hu1_ff - 16'(16'(hq1_ff) * 16'(DEG_FULL));
      r2_adj  = 10'(r2_full[8:0]) + (neg1_ff ? 10'(HUE_NEG_ADJ) : 10'd0);
      hw2_in  = (r2_adj >= 10'(DEG_FULL)) ? 9'(r2_adj - 10'(DEG_FULL)) : r2_adj[8:0];
   end

   always_ff @(posedge clock) begin
      side2_ff <= side1_ff;
      hw2_ff   <= hw2_in;
   end

   // ---- stage 3 ----
   assign sect_prod = 19'(hw2_ff) * 19'(SECT_RECIP);

   always_comb begin
      side3_in        = side2_ff;
      side3_in.sector = sect_prod[17:15];
   end

   always_ff @(posedge clock) begin
      side3_ff <= side3_in;
      hw3_ff   <= hw2_ff;
   end

   // ---- stage 4 ----
   assign sect60 = 9'(side3_ff.sector) * 9'(DEG_SECTOR);
   assign fn4_in = 6'(hw3_ff - sect60);

   always_ff @(posedge clock) begin
      side4_ff <= side3_ff;
      fn4_ff   <= fn4_in;
   end

   // ---- stage 5 ----
   assign fn_c  = 6'(DEG_SECTOR) - fn4_ff;
   assign sfn   = 14'(side4_ff.sat) * 14'(fn4_ff);
   assign sfn_c = 14'(side4_ff.sat) * 14'(fn_c);

   always_ff @(posedge clock) begin
      side5_ff <= side4_ff;
      np5_ff   <= 8'(FRAC_ONE) - side4_ff.sat;
      nq5_ff   <= 14'(DEN_QT) - sfn;
      nt5_ff   <= 14'(DEN_QT) - sfn_c;
   end

   // ---- stage 6 ----
   always_ff @(posedge clock) begin
      side6_ff <= side5_ff;
      xp6_ff   <= 16'(side5_ff.bri) * 16'(np5_ff);
      xq6_ff   <= 22'(side5_ff.bri) * 22'(nq5_ff);
      xt6_ff   <= 22'(side5_ff.bri) * 22'(nt5_ff);
   end

   // ---- stages 7-8 ----
   hsvrgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .xp        (xp6_ff),
      .xq        (xq6_ff),
      .xt        (xt6_ff),
      .out_valid (v8),
      .p         (p8),
      .q         (q8),
      .t         (t8)
   );

   always_ff @(posedge clock) begin
      side7_ff <= side6_ff;
      side8_ff <= side7_ff;
   end

   // ---- stage 9: channel assignment by sector ----
   always_comb begin
      unique case (side8_ff.sector)
         SECT_RED_YEL: begin
            red_in = side8_ff.bri; green_in = t8; blue_in = p8;
         end
         SECT_YEL_GRN: begin
            red_in = q8; green_in = side8_ff.bri; blue_in = p8;
         end
         SECT_GRN_CYAN: begin
            red_in = p8; green_in = side8_ff.bri; blue_in = t8;
         end
         SECT_CYAN_BLUE: begin
            red_in = p8; green_in = q8; blue_in = side8_ff.bri;
         end
         SECT_BLUE_MAG: begin
            red_in = t8; green_in = p8; blue_in = side8_ff.bri;
         end
         default: begin
            red_in = side8_ff.bri; green_in = p8; blue_in = q8;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      alpha9_ff <= side8_ff.alpha;
      red9_ff   <= red_in;
      green9_ff <= green_in;
      blue9_ff  <= blue_in;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v9_ff <= v8;
      end
   end

   assign rsp_valid     = v9_ff;
   assign rsp_alpha_out = alpha9_ff;
   assign rsp_red       = red9_ff;
   assign rsp_green     = green9_ff;
   assign rsp_blue      = blue9_ff;

   // ---- assertions ----
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##9 rsp_valid)
      else $error("transfer did not produce a result nine cycles later");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 9))
      else $error("result without a matching transfer");

   a_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_saturation == 8'd0, 9))
         |-> (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("zero saturation gave unequal channels");

   a_max_is_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red == $past(req_brightness, 9)
                  || rsp_green == $past(req_brightness, 9)
                  || rsp_blue == $past(req_brightness, 9)))
      else $error("no channel carries the value component");

endmodule

// ===== tb/hsv_to_rgb_argb_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_argb_core_tb
// Drives directed and random-burst HSV plus alpha colors into the core and
// compares every ARGB result, in order, against colors computed in the bench.
// ----------------------------------------------------------------------------

class argb_scoreboard;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } argb_type;

   argb_type pending_colors[$];
   int       mismatches;
   int       colors_checked;

   function new();
      mismatches     = 0;
      colors_checked = 0;
   endfunction

   // exact integer HSV to RGB, hue wrapped into 0..359
   function argb_type convert_hsv(logic [7:0] alpha, logic signed [15:0] hue,
                                  logic [7:0] saturation, logic [7:0] brightness);
      int         deg;
      int         sat;
      int         val;
      int         fn;
      int         p;
      int         q;
      int         t;
      logic [2:0] sector;
      argb_type   color;
      deg = hue;
      deg = deg % hsvrgb_pkg::DEG_FULL;
      if (deg < 0) deg += hsvrgb_pkg::DEG_FULL;
      sector = 3'(deg / hsvrgb_pkg::DEG_SECTOR);
      fn     = deg % hsvrgb_pkg::DEG_SECTOR;
      sat    = saturation;
      val    = brightness;
      p = val * (hsvrgb_pkg::FRAC_ONE - sat) / hsvrgb_pkg::FRAC_ONE;
      q = val * (hsvrgb_pkg::DEN_QT - sat * fn) / hsvrgb_pkg::DEN_QT;
      t = val * (hsvrgb_pkg::DEN_QT - sat * (hsvrgb_pkg::DEG_SECTOR - fn))
          / hsvrgb_pkg::DEN_QT;
      color.alpha = alpha;
      case (sector)
         hsvrgb_pkg::SECT_RED_YEL: begin
            color.red = 8'(val); color.green = 8'(t);   color.blue = 8'(p);
         end
         hsvrgb_pkg::SECT_YEL_GRN: begin
            color.red = 8'(q);   color.green = 8'(val); color.blue = 8'(p);
         end
         hsvrgb_pkg::SECT_GRN_CYAN: begin
            color.red = 8'(p);   color.green = 8'(val); color.blue = 8'(t);
         end
         hsvrgb_pkg::SECT_CYAN_BLUE: begin
            color.red = 8'(p);   color.green = 8'(q);   color.blue = 8'(val);
         end
         hsvrgb_pkg::SECT_BLUE_MAG: begin
            color.red = 8'(t);   color.green = 8'(p);   color.blue = 8'(val);
         end
         default: begin
            color.red = 8'(val); color.green = 8'(p);   color.blue = 8'(q);
         end
      endcase
      return color;
   endfunction

   function void note_input(logic [7:0] alpha, logic signed [15:0] hue,
                            logic [7:0] saturation, logic [7:0] brightness);
      pending_colors.push_back(convert_hsv(alpha, hue, saturation, brightness));
   endfunction

   function void compare_field(string name, logic [7:0] expected, logic [7:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
         mismatches++;
      end
   endfunction

   function void check_color(logic [7:0] alpha, logic [7:0] red,
                             logic [7:0] green, logic [7:0] blue);
      argb_type expected;
      if (pending_colors.size() == 0) begin
         $error("result with no transfer pending: a=%0d r=%0d g=%0d b=%0d",
                alpha, red, green, blue);
         mismatches++;
         return;
      end
      expected = pending_colors.pop_front();
      colors_checked++;
      compare_field("alpha_out", expected.alpha, alpha);
      compare_field("red", expected.red, red);
      compare_field("green", expected.green, green);
      compare_field("blue", expected.blue, blue);
   endfunction

endclass

module hsv_to_rgb_argb_core_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 900;
   localparam int DRAIN_CYCLES = 20;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               busy;
   logic [7:0]         req_alpha_in   = 8'd0;
   logic signed [15:0] req_hue        = 16'sd0;
   logic [7:0]         req_saturation = 8'd0;
   logic [7:0]         req_brightness = 8'd0;
   logic               rsp_valid;
   logic [7:0]         rsp_alpha_out;
   logic [7:0]         rsp_red;
   logic [7:0]         rsp_green;
   logic [7:0]         rsp_blue;

   argb_scoreboard board = new();
   int             items_sent  = 0;
   int             cycle_count = 0;

   hsv_to_rgb_argb_core uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_alpha_in   (req_alpha_in),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_alpha_out  (rsp_alpha_out),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // transfers and results are both sampled on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_input(req_alpha_in, req_hue, req_saturation, req_brightness);
         if (rsp_valid === 1'b1)
            board.check_color(rsp_alpha_out, rsp_red, rsp_green, rsp_blue);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("hsv_to_rgb_argb_core_tb failed");
      $finish;
   end

   task automatic send_color(input logic [7:0] alpha, input logic signed [15:0] hue,
                             input logic [7:0] saturation, input logic [7:0] brightness);
      @(negedge clock);
      start          <= 1'b1;
      req_alpha_in   <= alpha;
      req_hue        <= hue;
      req_saturation <= saturation;
      req_brightness <= brightness;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // start low, fields carry junk
   task automatic idle_cycles(input int count);
      repeat (count) begin
         @(negedge clock);
         start          <= 1'b0;
         req_alpha_in   <= 8'($urandom);
         req_hue        <= 16'($urandom);
         req_saturation <= 8'($urandom);
         req_brightness <= 8'($urandom);
      end
   endtask

   function automatic logic [7:0] pick_fraction();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_color();
      logic signed [15:0] hue;
      logic [7:0]         sat;
      logic [7:0]         bri;
      sat = 8'($urandom);
      bri = 8'($urandom);
      case ($urandom_range(0, 3))
         0: hue = 16'($urandom);
         1: hue = 16'(int'($urandom_range(0, 1440)) - 720);
         2: begin
            hue = 16'($urandom);
            sat = pick_fraction();
            bri = pick_fraction();
         end
         // near a sector edge, within two turns either way
         default: hue = 16'((int'($urandom_range(0, 24)) - 12) * 60
                            + int'($urandom_range(0, 2)) - 1);
      endcase
      send_color(8'($urandom), hue, sat, bri);
   endtask

   initial begin
      int burst_len;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: wrap corners, sector boundaries, field extremes
      send_color(8'd0,   16'sd0,      8'd255, 8'd255);
      send_color(8'd255, 16'sd59,     8'd255, 8'd255);
      send_color(8'd17,  16'sd60,     8'd255, 8'd255);
      send_color(8'd34,  16'sd120,    8'd255, 8'd255);
      send_color(8'd51,  16'sd180,    8'd255, 8'd255);
      send_color(8'd68,  16'sd240,    8'd255, 8'd255);
      send_color(8'd85,  16'sd300,    8'd255, 8'd255);
      send_color(8'd102, 16'sd359,    8'd255, 8'd255);
      send_color(8'd119, 16'sd360,    8'd200, 8'd180);
      send_color(8'd136, 16'sd719,    8'd200, 8'd180);
      send_color(8'd153, -16'sd1,     8'd200, 8'd180);
      send_color(8'd170, -16'sd360,   8'd200, 8'd180);
      send_color(8'd187, -16'sd361,   8'd128, 8'd255);
      send_color(8'd204, -16'sd32768, 8'd128, 8'd255);
      send_color(8'd221, 16'sd32767,  8'd128, 8'd255);
      send_color(8'd238, 16'sd90,     8'd0,   8'd200);
      send_color(8'd1,   -16'sd150,   8'd0,   8'd77);
      send_color(8'd2,   16'sd210,    8'd255, 8'd0);
      send_color(8'd3,   16'sd30,     8'd0,   8'd0);
      send_color(8'd4,   16'sd330,    8'd1,   8'd1);
      send_color(8'd5,   16'sd150,    8'd254, 8'd254);
      send_color(8'd6,   16'sd270,    8'd255, 8'd1);
      idle_cycles(3);

      while (items_sent < RANDOM_ITEMS + 22) begin
         burst_len = $urandom_range(1, 48);
         repeat (burst_len) send_random_color();
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 9));
      end
      idle_cycles(1);

      while (board.pending_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.pending_colors.size() != 0) begin
         $error("%0d expected colors never arrived", board.pending_colors.size());
         board.mismatches++;
      end
      $display("sent %0d colors (sector edges, hue wrap, extreme s/v, random bursts)",
               items_sent);
      $display("checked %0d results, %0d mismatches", board.colors_checked,
               board.mismatches);
      if (board.mismatches == 0) begin
         $display("hsv_to_rgb_argb_core_tb passed");
      end else begin
         $display("hsv_to_rgb_argb_core_tb failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_scale.sv
rtl/core/hsv_to_rgb_argb_core.sv
tb/hsv_to_rgb_argb_core_tb.sv
